@@ sv/alpe_pkg.sv @@
// ============================================================================
// alpe_pkg: shared types and constants for the LED pulse encoder
// Request codes, register map, payload structs and scaling constants.
// ============================================================================
package alpe_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EMIT  = 2'd1;
  localparam logic [1:0] REQ_LATCH = 2'd2;

  // Register map, word index (byte address 4*i)
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_HIGH_ONE   = 2'd1;
  localparam logic [1:0] REG_HIGH_ZERO  = 2'd2;
  localparam logic [1:0] REG_LATCH      = 2'd3;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  // Register reset values
  localparam logic [6:0] BRIGHTNESS_RST = 7'd0;
  localparam logic [7:0] HIGH_ONE_RST   = 8'd43;
  localparam logic [7:0] HIGH_ZERO_RST  = 8'd17;
  localparam logic [6:0] LATCH_RST      = 7'd50;

  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned MaxGap     = 64;
  localparam int unsigned FullScale  = 100;

  // floor(x/100) == (x * Recip) >> RecipShift for x below 25600
  localparam int unsigned RecipShift = 20;
  localparam int unsigned Recip      = (1 << RecipShift) / FullScale + 1;

  localparam int unsigned MulAWidth = 8;
  localparam int unsigned MulBWidth = 21;
  localparam int unsigned MulPWidth = MulAWidth + MulBWidth;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } alpe_in_t;

  typedef struct packed {
    logic [7:0] slot_value;
    logic       last_slot;
  } alpe_out_t;

endpackage

@@ sv/alpe_color_mem.sv @@
// ============================================================================
// alpe_color_mem: LED color store
// One write and one registered read port; entries never written read as zero.
// ============================================================================
module alpe_color_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [23:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [23:0]      rdata_o
);

  logic [23:0]      mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [23:0]      rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/alpe_mul.sv @@
// ============================================================================
// alpe_mul: shared scaling multiplier
// 8 x 21 bit unsigned product, registered.
// ============================================================================
module alpe_mul (
  input  logic                         clk_i,
  input  logic [alpe_pkg::MulAWidth-1:0] a_i,
  input  logic [alpe_pkg::MulBWidth-1:0] b_i,
  output logic [alpe_pkg::MulPWidth-1:0] p_o
);
  import alpe_pkg::*;

  logic [MulPWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPWidth'(a_i) * MulPWidth'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ sv/addressable_led_pulse_encoder_unit.sv @@
// ============================================================================
// addressable_led_pulse_encoder_unit: RGB LED one-wire slot encoder
// Stores LED colors, scales them by brightness and emits one PWM compare
// value per bit slot, plus zero-filled latch gaps.
// ============================================================================
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o / in_data_i      | write, emit or latch item
//  out     | out_valid_o / out_ready_i / out_data_o   | one slot value per item
//  cfg     | psel, penable, pwrite, paddr, pwdata ... | APB register access
//
//  Steps: a write item is taken in ST_IDLE alone. An emit item passes through
//  ST_MULK, ST_MULG, ST_MULR, ST_MULB and ST_MULW (four passes through the one
//  shared multiplier) and then ST_SLOT for 24 slots. A latch item runs ST_SLOT
//  for one zero slot per gap slot (at most 64).
//  Slots leave at one per cycle while out_ready_i is high; a stall holds the
//  slot sequencer. in_ready_o is high only while the sequencer is idle.
//  Reset clears the color store (per-entry valid bits) and the registers.
//
module addressable_led_pulse_encoder_unit #(
  parameter int unsigned LED_COUNT = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // item input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  alpe_pkg::alpe_in_t                    in_data_i,
  // slot output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output alpe_pkg::alpe_out_t                   out_data_o,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [alpe_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [alpe_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [alpe_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                  pready
);
  import alpe_pkg::*;

  // led_index is 6 bits, so at most 64 entries are reachable
  localparam int unsigned Depth = (LED_COUNT < 64) ? LED_COUNT : 64;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULK,   // k = brightness * reciprocal
    ST_MULG,   // green * k
    ST_MULR,   // red * k, take green
    ST_MULB,   // blue * k, take red
    ST_MULW,   // take blue
    ST_SLOT    // serialize slots
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] bright_q;
  logic [7:0] high_one_q;
  logic [7:0] high_zero_q;
  logic [6:0] latch_q;
  logic       cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= BRIGHTNESS_RST;
      high_one_q  <= HIGH_ONE_RST;
      high_zero_q <= HIGH_ZERO_RST;
      latch_q     <= LATCH_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BRIGHTNESS: bright_q    <= pwdata[6:0];
        REG_HIGH_ONE:   high_one_q  <= pwdata[7:0];
        REG_HIGH_ZERO:  high_zero_q <= pwdata[7:0];
        REG_LATCH:      latch_q     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_BRIGHTNESS: prdata[6:0] = bright_q;
      REG_HIGH_ONE:   prdata[7:0] = high_one_q;
      REG_HIGH_ZERO:  prdata[7:0] = high_zero_q;
      REG_LATCH:      prdata[6:0] = latch_q;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  state_e     state_q;
  logic       accept;
  logic       in_range;
  logic [6:0] bright_sat;
  logic [6:0] gap_len;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(in_data_i.led_index) < LED_COUNT;

  // brightness above full scale saturates; gap length saturates at 64
  assign bright_sat = (bright_q > 7'(FullScale)) ? 7'(FullScale) : bright_q;
  assign gap_len    = (latch_q > 7'(MaxGap)) ? 7'(MaxGap) : latch_q;

  // --------------------------------------------------------------------------
  // Color store
  // --------------------------------------------------------------------------
  logic        mem_we;
  logic [23:0] mem_rdata;

  assign mem_we = accept && (in_data_i.req_type == REQ_WRITE) && in_range;

  alpe_color_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (in_data_i.led_index[AddrW-1:0]),
    .wdata_i ({in_data_i.green, in_data_i.red, in_data_i.blue}),
    .re_i    (accept),
    .raddr_i (in_data_i.led_index[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier: first builds k = brightness * Recip, then scales
  // each channel as (c * k) >> RecipShift, which equals floor(c*b/100).
  // --------------------------------------------------------------------------
  logic [MulAWidth-1:0] mul_a;
  logic [MulBWidth-1:0] mul_b;
  logic [MulPWidth-1:0] mul_p;
  logic [23:0]          color_q;
  logic [MulBWidth-1:0] k_q;
  logic [7:0]           scaled;

  always_comb begin
    unique case (state_q)
      ST_MULK: begin
        mul_a = MulAWidth'(bright_sat);
        mul_b = MulBWidth'(Recip);
      end
      ST_MULG: begin
        mul_a = color_q[23:16];
        mul_b = mul_p[MulBWidth-1:0];
      end
      ST_MULR: begin
        mul_a = color_q[15:8];
        mul_b = k_q;
      end
      ST_MULB: begin
        mul_a = color_q[7:0];
        mul_b = k_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  alpe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign scaled = mul_p[RecipShift+7:RecipShift];

  // --------------------------------------------------------------------------
  // Sequencer and slot output register
  // --------------------------------------------------------------------------
  logic       range_q;
  logic       gap_q;     // serializing a latch gap
  logic [23:0] word_q;   // GRB, MSB leaves first
  logic [6:0] rem_q;     // slots left in this run
  logic       out_valid_q;
  alpe_out_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      gap_q       <= 1'b0;
      range_q     <= 1'b0;
    end else begin
      // while serializing, the slot branch below owns out_valid_q
      if (out_valid_q && out_ready_i && state_q != ST_SLOT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            range_q <= in_range;
            if (in_data_i.req_type == REQ_EMIT) begin
              state_q <= ST_MULK;
            end else if (in_data_i.req_type == REQ_LATCH && gap_len != '0) begin
              gap_q   <= 1'b1;
              rem_q   <= gap_len;
              state_q <= ST_SLOT;
            end
          end
        end
        ST_MULK: begin
          // out-of-range emit encodes the color zero
          color_q <= range_q ? mem_rdata : '0;
          state_q <= ST_MULG;
        end
        ST_MULG: begin
          k_q     <= mul_p[MulBWidth-1:0];
          state_q <= ST_MULR;
        end
        ST_MULR: begin
          word_q  <= {word_q[15:0], scaled};
          state_q <= ST_MULB;
        end
        ST_MULB: begin
          word_q  <= {word_q[15:0], scaled};
          state_q <= ST_MULW;
        end
        ST_MULW: begin
          word_q  <= {word_q[15:0], scaled};
          gap_q   <= 1'b0;
          rem_q   <= 7'(BitsPerLed);
          state_q <= ST_SLOT;
        end
        ST_SLOT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.slot_value <= gap_q ? 8'd0 : (word_q[23] ? high_one_q : high_zero_q);
            out_q.last_slot  <= (rem_q == 7'd1);
            word_q           <= {word_q[22:0], 1'b0};
            rem_q            <= rem_q - 7'd1;
            if (rem_q == 7'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the addressable LED pulse encoder
// Drives write, emit and latch items through the valid/ready input, programs
// the APB registers between phases, and checks every slot that leaves the
// output against an in-bench model of the color store and slot encoder.
// A short table of directed items runs first, then random phases.
// ============================================================================
module tb_top;
  import alpe_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 100;       // beyond the longest latch run
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RAND_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned MAX_WAIT      = 5;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;     // request code with no meaning

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table: either a register write or an item.
  // Items with fixed_run set carry their expected slots inline (a run of
  // fixed_cnt equal values); the rest go through the slot model.
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    alpe_in_t    item;
    bit          fixed_run;
    logic [7:0]  fixed_val;
    int unsigned fixed_cnt;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  alpe_in_t                in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  alpe_out_t               out_data_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  addressable_led_pulse_encoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Slot model: shadow color store, shadow registers, queue of slots due
  // --------------------------------------------------------------------------
  logic [23:0] led_colors [64];     // {green, red, blue}
  logic [6:0]  bright_pct;
  logic [7:0]  one_slot_val;
  logic [7:0]  zero_slot_val;
  logic [6:0]  gap_len;
  alpe_out_t   slots_due [$];

  int unsigned mismatch_cnt;
  int unsigned sent_items;
  int unsigned taken_slots;
  int unsigned cycle_cnt;

  task automatic clear_model();
    for (int i = 0; i < 64; i++) begin
      led_colors[i] = '0;
    end
    bright_pct    = BRIGHTNESS_RST;
    one_slot_val  = HIGH_ONE_RST;
    zero_slot_val = HIGH_ZERO_RST;
    gap_len       = LATCH_RST;
  endtask

  task automatic shadow_reg_write(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_BRIGHTNESS: bright_pct    = val[6:0];
      REG_HIGH_ONE:   one_slot_val  = val[7:0];
      REG_HIGH_ZERO:  zero_slot_val = val[7:0];
      REG_LATCH:      gap_len       = val[6:0];
      default: ;
    endcase
  endtask

  // floor(c * pct / 100), brightness above full scale saturates
  function automatic logic [7:0] scale_chan(logic [7:0] chan);
    int unsigned pct;
    pct = bright_pct;
    if (pct > FullScale) pct = FullScale;
    return 8'((chan * pct) / FullScale);
  endfunction

  task automatic push_slot_run(logic [7:0] val, int unsigned cnt);
    alpe_out_t s;
    for (int unsigned k = 0; k < cnt; k++) begin
      s.slot_value = val;
      s.last_slot  = (k + 1 == cnt);
      slots_due.push_back(s);
    end
  endtask

  // Update the shadow store and queue the slots one accepted item causes.
  task automatic encode_request(alpe_in_t it);
    logic [23:0] grb;
    alpe_out_t   s;
    int unsigned n;
    case (it.req_type)
      REQ_WRITE: led_colors[it.led_index] = {it.green, it.red, it.blue};
      REQ_EMIT: begin
        grb = led_colors[it.led_index];
        grb = {scale_chan(grb[23:16]), scale_chan(grb[15:8]), scale_chan(grb[7:0])};
        // GRB, MSB first
        for (int k = BitsPerLed - 1; k >= 0; k--) begin
          s.slot_value = grb[k] ? one_slot_val : zero_slot_val;
          s.last_slot  = (k == 0);
          slots_due.push_back(s);
        end
      end
      REQ_LATCH: begin
        n = gap_len;
        if (n > MaxGap) n = MaxGap;
        push_slot_run(8'd0, n);
      end
      default: ;  // unused code: no slots, no state change
    endcase
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN) begin
      $display("[%0t] slot %0d %s: expected %0d got %0d", $realtime, taken_slots,
               what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Slot receiver: random stalls per slot, quiet stretches with ready held
  // high, and the field-by-field check of each accepted slot.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    alpe_out_t   want;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = ((taken_slots / 120) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      taken_slots++;
      if (slots_due.size() == 0) begin
        note_mismatch("arrived with nothing due, slot_value", 0, out_data_o.slot_value);
      end else begin
        want = slots_due.pop_front();
        if (out_data_o.slot_value !== want.slot_value)
          note_mismatch("slot_value", want.slot_value, out_data_o.slot_value);
        if (out_data_o.last_slot !== want.last_slot)
          note_mismatch("last_slot", want.last_slot, out_data_o.last_slot);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item sender and register access. All of these are entered right after a
  // rising edge; in_valid_i is either handed the next item or dropped in the
  // same step in which the previous item was taken, so nothing is taken twice.
  // --------------------------------------------------------------------------
  task automatic send_item(alpe_in_t it, bit fixed_run = 1'b0,
                           logic [7:0] fixed_val = '0, int unsigned fixed_cnt = 0);
    int unsigned gap;
    gap = ((sent_items / 40) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sent_items++;
    if (fixed_run) push_slot_run(fixed_val, fixed_cnt);
    else encode_request(it);
  endtask

  // Drop valid, let every due slot drain, then let the sequencer settle.
  task automatic wait_idle(int unsigned settle);
    in_valid_i <= 1'b0;
    while (slots_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; register takes the value at the access edge.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_reg_write(idx, val);
  endtask

  function automatic dir_row_t item_row(logic [1:0] rt, logic [5:0] idx,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        bit fx = 1'b0, logic [7:0] fv = '0,
                                        int unsigned fc = 0);
    dir_row_t row;
    row.kind           = ROW_ITEM;
    row.reg_idx        = '0;
    row.reg_val        = '0;
    row.item.req_type  = rt;
    row.item.led_index = idx;
    row.item.red       = r;
    row.item.green     = g;
    row.item.blue      = b;
    row.fixed_run      = fx;
    row.fixed_val      = fv;
    row.fixed_cnt      = fc;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    dir_row_t row;
    row           = item_row(REQ_WRITE, '0, '0, '0, '0);
    row.kind      = ROW_CFG;
    row.reg_idx   = idx;
    row.reg_val   = val;
    return row;
  endfunction

  function automatic alpe_in_t random_request();
    alpe_in_t    it;
    int unsigned pick;
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    // half the traffic lands on a few hot LEDs so emits mostly see written colors
    it.led_index = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 35)      it.req_type = REQ_WRITE;
    else if (pick < 80) it.req_type = REQ_EMIT;
    else if (pick < 95) it.req_type = REQ_LATCH;
    else                it.req_type = REQ_UNUSED;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t    rows [$];
    logic [31:0] junk;
    logic [6:0]  br;
    logic [7:0]  t_one;
    logic [7:0]  t_zero;
    logic [6:0]  gl;

    mismatch_cnt = 0;
    sent_items   = 0;
    taken_slots  = 0;
    clear_model();

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Rows with an inline run are the obvious cases.
    // dark start and cleared store: every bit is a zero slot
    rows.push_back(item_row(REQ_EMIT, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, HIGH_ZERO_RST, BitsPerLed));
    rows.push_back(item_row(REQ_LATCH, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, int'(LATCH_RST)));
    rows.push_back(cfg_row(REG_BRIGHTNESS, 32'd100));
    rows.push_back(item_row(REQ_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF));
    rows.push_back(item_row(REQ_EMIT, 6'd63, 8'h00, 8'h00, 8'h00, 1'b1, HIGH_ONE_RST, BitsPerLed));
    rows.push_back(item_row(REQ_WRITE, 6'd0, 8'h00, 8'h00, 8'h00));
    rows.push_back(item_row(REQ_EMIT, 6'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, HIGH_ZERO_RST, BitsPerLed));
    rows.push_back(item_row(REQ_WRITE, 6'd5, 8'hA5, 8'h5A, 8'h3C));
    rows.push_back(item_row(REQ_EMIT, 6'd5, 8'h00, 8'h00, 8'h00));
    // brightness above full scale saturates: same slots as at 100
    rows.push_back(cfg_row(REG_BRIGHTNESS, 32'd127));
    rows.push_back(item_row(REQ_EMIT, 6'd5, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_BRIGHTNESS, 32'd50));
    rows.push_back(item_row(REQ_EMIT, 6'd63, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_HIGH_ONE, 32'd255));
    rows.push_back(cfg_row(REG_HIGH_ZERO, 32'd0));
    rows.push_back(item_row(REQ_EMIT, 6'd63, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_HIGH_ONE, 32'd0));
    rows.push_back(cfg_row(REG_HIGH_ZERO, 32'd255));
    rows.push_back(item_row(REQ_EMIT, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd255, BitsPerLed));
    // empty gap, full gap, saturated gap, single slot
    rows.push_back(cfg_row(REG_LATCH, 32'd0));
    rows.push_back(item_row(REQ_LATCH, 6'd63, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 0));
    rows.push_back(cfg_row(REG_LATCH, 32'd64));
    rows.push_back(item_row(REQ_LATCH, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, MaxGap));
    rows.push_back(cfg_row(REG_LATCH, 32'd127));
    rows.push_back(item_row(REQ_LATCH, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, MaxGap));
    rows.push_back(cfg_row(REG_LATCH, 32'd1));
    rows.push_back(item_row(REQ_LATCH, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 1));
    // unused request code must leave LED 5 alone
    rows.push_back(item_row(REQ_UNUSED, 6'd5, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0, 0));
    rows.push_back(item_row(REQ_EMIT, 6'd5, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_BRIGHTNESS, 32'd1));
    rows.push_back(item_row(REQ_EMIT, 6'd63, 8'h00, 8'h00, 8'h00));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle(SETTLE_CYCLES);
        cfg_write(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].item, rows[i].fixed_run, rows[i].fixed_val, rows[i].fixed_cnt);
      end
    end

    // Random phases: reprogram all four registers while idle, then a burst
    // of random items. Early phases pin the extremes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      t_one  = 8'($urandom);
      t_zero = 8'($urandom);
      case (p)
        0: begin br = 7'd100; t_one = 8'hFF; t_zero = 8'h00; gl = 7'd64; end
        1: begin br = 7'd0; gl = 7'd1; end
        2: begin br = 7'd127; gl = 7'd0; end
        3: begin br = 7'($urandom_range(1, 99)); gl = 7'd127; end
        4: begin br = 7'd101; gl = 7'($urandom_range(1, 64)); end
        default: begin
          br = 7'($urandom_range(0, 127));
          gl = 7'($urandom_range(0, 127));
        end
      endcase
      // later phases also toggle the unused upper data bits
      junk = (p >= 4) ? $urandom : 32'd0;
      wait_idle(SETTLE_CYCLES);
      cfg_write(REG_BRIGHTNESS, {junk[31:7], br});
      cfg_write(REG_HIGH_ONE, {junk[31:8], t_one});
      cfg_write(REG_HIGH_ZERO, {junk[31:8], t_zero});
      cfg_write(REG_LATCH, {junk[31:7], gl});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then hold off until the output has fully drained
        if ($urandom_range(0, 29) == 0) wait_idle(1);
        send_item(random_request());
      end
    end

    wait_idle(TAIL_CYCLES);
    if (mismatch_cnt == 0 && slots_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
